// ===== hw/rtl/slps_pkg.sv =====
// types, constants and helpers for the status led pattern sequencer
`default_nettype none

package slps_pkg;

	localparam int unsigned PhaseW = 7;
	localparam int unsigned LevelW = 3;

	typedef logic [PhaseW-1:0] phase_t;
	typedef logic [LevelW-1:0] level_t;
	typedef logic [PhaseW-1:0] signal_t;

	typedef struct packed {
		logic    power_off;
		logic    modem_init;
		logic    ota_active;
		level_t  network_level;
		logic    link_active;
		logic    alarm;
		logic    low_battery;
		level_t  key_test;
		logic    no_sim;
		logic    data_connected;
		signal_t gps_signal;
		logic    gps_fix;
	} status_t;

	typedef struct packed {
		logic work_led;
		logic gps_led;
		logic modem_led;
		logic data_led;
	} leds_t;

	// key test codes
	localparam level_t KEY_NONE  = 3'd0;
	localparam level_t KEY_DATA  = 3'd1;
	localparam level_t KEY_WORK  = 3'd2;
	localparam level_t KEY_GPS   = 3'd3;
	localparam level_t KEY_MODEM = 3'd4;

	localparam level_t NET_LEVEL_1 = 3'd2;
	localparam level_t NET_LEVEL_2 = 3'd3;
	localparam level_t NET_LEVEL_3 = 3'd4;

	localparam signal_t THRESHOLD_RESET = 7'd15;

	// cycle ends of the phase counters
	localparam phase_t MODEM_INIT_END = 7'd20;
	localparam phase_t LINK_END       = 7'd40;
	localparam phase_t CYCLE_END      = 7'd100;
	localparam phase_t ALARM_END      = 7'd80;
	localparam phase_t NORMAL_END     = 7'd40;

	localparam phase_t GPS_ON_AT  = 7'd50;
	localparam phase_t GPS_OFF_AT = 7'd52;

	function automatic phase_t count_to(input phase_t v, input phase_t last);
		return (v >= last) ? '0 : phase_t'(v + 7'd1);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slps_chan_if.sv =====
// valid/ready channel carrying one payload beat
`default_nettype none

interface slps_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/status_led_pattern_sequencer.sv =====
// status led pattern sequencer: one status tick in, four led levels out
// an accepted status beat passes the input register and then the led register to become its led beat
// one beat per cycle while the led channel is not stalled; the phase counters and led levels update in one pass
// a stalled led beat holds the input register, and status is still taken while it is empty
// reset: phases zero, all leds off, signal threshold 15, both stages empty
`default_nettype none

module status_led_pattern_sequencer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	slps_chan_if.sink         cfg,
	slps_chan_if.sink         status,
	slps_chan_if.source       leds
);
	import slps_pkg::*;

	status_t status_s1;
	logic    valid_s1;
	logic    valid_s2;
	logic    advance;

	signal_t threshold_q;
	phase_t  net_phase_q;
	phase_t  modem_phase_q;
	phase_t  power_phase_q;
	leds_t   led_q;

	phase_t  net_d;
	phase_t  modem_d;
	phase_t  power_d;
	leds_t   led_d;

	assign advance      = !valid_s2 || leds.ready;
	assign status.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;
	assign leds.valid   = valid_s2;
	assign leds.data    = led_q;

	always_ff @(posedge clk) begin
		if (status.valid && status.ready) begin
			status_s1 <= status.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (status.ready) begin
				valid_s1 <= status.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg.valid) begin
			threshold_q <= cfg.data;
		end
	end

	// one tick through the priority chain
	always_comb begin
		phase_t old_net;
		old_net = net_phase_q;
		net_d   = net_phase_q;
		modem_d = modem_phase_q;
		power_d = power_phase_q;
		led_d   = led_q;

		if (status_s1.power_off) begin
			led_d = '0;
		end else if (status_s1.modem_init) begin
			modem_d = count_to(modem_phase_q, MODEM_INIT_END);
			if (modem_d == 7'd1) begin
				led_d.modem_led = 1'b1;
			end else if (modem_d == 7'd2) begin
				led_d.modem_led = 1'b0;
			end
		end else if (status_s1.ota_active) begin
			if (modem_phase_q != '0) begin
				modem_d         = '0;
				led_d.modem_led = 1'b1;
				led_d.gps_led   = 1'b0;
			end else begin
				modem_d         = 7'd1;
				led_d.modem_led = 1'b0;
				led_d.gps_led   = 1'b1;
			end
		end else begin
			// network strength pulses on the data led
			net_d = phase_t'(old_net + 7'd1);
			case (old_net)
				7'd1, 7'd8: begin
					if (status_s1.network_level >= NET_LEVEL_1) led_d.data_led = 1'b1;
				end
				7'd15: begin
					if (status_s1.network_level >= NET_LEVEL_2) led_d.data_led = 1'b1;
				end
				7'd22: begin
					if (status_s1.network_level == NET_LEVEL_3) led_d.data_led = 1'b1;
				end
				7'd4, 7'd11, 7'd18, 7'd25: led_d.data_led = 1'b0;
				CYCLE_END: net_d = '0;
				default: ;
			endcase

			if (status_s1.link_active) begin
				modem_d = count_to(modem_phase_q, LINK_END);
				if (modem_d == 7'd1) begin
					led_d.modem_led = 1'b1;
				end else if (modem_d == 7'd2) begin
					led_d.modem_led = 1'b0;
				end
			end else begin
				power_d = count_to(power_phase_q, CYCLE_END);
				if (status_s1.alarm) begin
					case (power_d)
						7'd1, 7'd8:  led_d.work_led = 1'b1;
						7'd4, 7'd11: led_d.work_led = 1'b0;
						ALARM_END:   power_d = '0;
						default: ;
					endcase
				end else if (status_s1.low_battery) begin
					case (power_d)
						7'd1, 7'd8, 7'd15:  led_d.work_led = 1'b1;
						7'd4, 7'd11, 7'd18: led_d.work_led = 1'b0;
						default: ;
					endcase
				end else begin
					case (power_d)
						7'd1:       led_d.work_led = 1'b1;
						7'd4:       led_d.work_led = 1'b0;
						NORMAL_END: power_d = '0;
						default: ;
					endcase
				end

				case (status_s1.key_test)
					KEY_DATA:  led_d.data_led  = 1'b0;
					KEY_WORK:  led_d.work_led  = 1'b0;
					KEY_GPS:   led_d.gps_led   = 1'b0;
					KEY_MODEM: led_d.modem_led = 1'b0;
					default: ;
				endcase

				modem_d = count_to(modem_phase_q, CYCLE_END);
				case (modem_d)
					7'd1: begin
						if (!status_s1.no_sim) led_d.modem_led = 1'b1;
					end
					7'd8: begin
						if (!status_s1.no_sim && status_s1.data_connected &&
						    (status_s1.gps_signal > threshold_q)) begin
							led_d.modem_led = 1'b1;
						end
					end
					7'd4, 7'd11: led_d.modem_led = 1'b0;
					GPS_ON_AT: begin
						if (status_s1.gps_fix) led_d.gps_led = 1'b1;
					end
					GPS_OFF_AT: led_d.gps_led = 1'b0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_phase_q   <= '0;
			modem_phase_q <= '0;
			power_phase_q <= '0;
			led_q         <= '0;
		end else if (valid_s1 && advance) begin
			net_phase_q   <= net_d;
			modem_phase_q <= modem_d;
			power_phase_q <= power_d;
			led_q         <= led_d;
		end
	end

	a_power_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && status_s1.power_off |=> leds.valid && (led_q == '0))
		else $error("power-off beat did not blank the leds");

	a_net_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		net_phase_q <= CYCLE_END)
		else $error("net phase left its cycle");

	a_power_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		power_phase_q <= CYCLE_END)
		else $error("power phase left its cycle");

	a_modem_init_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && !status_s1.power_off && status_s1.modem_init
		|=> modem_phase_q <= MODEM_INIT_END)
		else $error("modem init phase beyond its end");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> status.ready)
		else $error("status stalled while led stage empty");

endmodule

`default_nettype wire

// ===== verif/status_led_pattern_sequencer_tb.sv =====
// self-checking testbench for the status led pattern sequencer
module status_led_pattern_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slps_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	slps_chan_if #(.T(signal_t)) cfg_ch ();
	slps_chan_if #(.T(status_t)) status_ch ();
	slps_chan_if #(.T(leds_t))   leds_ch ();

	status_led_pattern_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.status (status_ch),
		.leds   (leds_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the sequencer state
	signal_t threshold   = THRESHOLD_RESET;
	phase_t  net_count   = '0;
	phase_t  modem_count = '0;
	phase_t  work_count  = '0;
	leds_t   lit         = '0;

	leds_t expected_leds[$];
	int    errors = 0;
	int    send_calm = 0;
	int    recv_calm = 0;

	function automatic phase_t advance(input phase_t v, input phase_t last);
		return (v >= last) ? phase_t'(0) : phase_t'(v + 7'd1);
	endfunction

	function automatic leds_t predict_leds(input status_t s);
		phase_t prev;
		if (s.power_off) begin
			lit = '0;
			return lit;
		end
		if (s.modem_init) begin
			modem_count = advance(modem_count, MODEM_INIT_END);
			if (modem_count == 7'd1)
				lit.modem_led = 1'b1;
			else if (modem_count == 7'd2)
				lit.modem_led = 1'b0;
			return lit;
		end
		if (s.ota_active) begin
			if (modem_count != 7'd0) begin
				modem_count = '0;
				lit.modem_led = 1'b1;
				lit.gps_led = 1'b0;
			end else begin
				modem_count = 7'd1;
				lit.modem_led = 1'b0;
				lit.gps_led = 1'b1;
			end
			return lit;
		end

		// network strength pulses on the data led
		prev = net_count;
		net_count = phase_t'(prev + 7'd1);
		case (prev)
			7'd1, 7'd8: if (s.network_level >= NET_LEVEL_1) lit.data_led = 1'b1;
			7'd15: if (s.network_level >= NET_LEVEL_2) lit.data_led = 1'b1;
			7'd22: if (s.network_level == NET_LEVEL_3) lit.data_led = 1'b1;
			7'd4, 7'd11, 7'd18, 7'd25: lit.data_led = 1'b0;
			CYCLE_END: net_count = '0;
			default: ;
		endcase

		if (s.link_active) begin
			modem_count = advance(modem_count, LINK_END);
			if (modem_count == 7'd1)
				lit.modem_led = 1'b1;
			else if (modem_count == 7'd2)
				lit.modem_led = 1'b0;
			return lit;
		end

		work_count = advance(work_count, CYCLE_END);
		if (s.alarm) begin
			case (work_count)
				7'd1, 7'd8: lit.work_led = 1'b1;
				7'd4, 7'd11: lit.work_led = 1'b0;
				ALARM_END: work_count = '0;
				default: ;
			endcase
		end else if (s.low_battery) begin
			case (work_count)
				7'd1, 7'd8, 7'd15: lit.work_led = 1'b1;
				7'd4, 7'd11, 7'd18: lit.work_led = 1'b0;
				default: ;
			endcase
		end else begin
			case (work_count)
				7'd1: lit.work_led = 1'b1;
				7'd4: lit.work_led = 1'b0;
				NORMAL_END: work_count = '0;
				default: ;
			endcase
		end

		case (s.key_test)
			KEY_DATA: lit.data_led = 1'b0;
			KEY_WORK: lit.work_led = 1'b0;
			KEY_GPS: lit.gps_led = 1'b0;
			KEY_MODEM: lit.modem_led = 1'b0;
			default: ;
		endcase

		modem_count = advance(modem_count, CYCLE_END);
		case (modem_count)
			7'd1: if (!s.no_sim) lit.modem_led = 1'b1;
			7'd8: begin
				if (!s.no_sim && s.data_connected && s.gps_signal > threshold)
					lit.modem_led = 1'b1;
			end
			7'd4, 7'd11: lit.modem_led = 1'b0;
			GPS_ON_AT: if (s.gps_fix) lit.gps_led = 1'b1;
			GPS_OFF_AT: lit.gps_led = 1'b0;
			default: ;
		endcase
		return lit;
	endfunction

	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			threshold = cfg_ch.data;
	end

	always @(posedge clk) begin
		if (arst_n && status_ch.valid && status_ch.ready)
			expected_leds.push_back(predict_leds(status_ch.data));
	end

	task automatic check_bit(input string name, input logic want, input logic got);
		if (want !== got) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		leds_t want;
		if (arst_n && leds_ch.valid && leds_ch.ready) begin
			if (expected_leds.size() == 0) begin
				$error("led beat with nothing expected: %b", leds_ch.data);
				errors++;
			end else begin
				want = expected_leds.pop_front();
				check_bit("work_led", want.work_led, leds_ch.data.work_led);
				check_bit("gps_led", want.gps_led, leds_ch.data.gps_led);
				check_bit("modem_led", want.modem_led, leds_ch.data.modem_led);
				check_bit("data_led", want.data_led, leds_ch.data.data_led);
			end
		end
	end

	// runs of back-to-back beats now and then, otherwise a random idle gap
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	initial begin : led_sink
		int gap;
		leds_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				leds_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			leds_ch.ready <= 1'b1;
			@(posedge clk);
			while (!leds_ch.valid) @(posedge clk);
		end
	end

	task automatic send_status(input status_t s);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			status_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		status_ch.valid <= 1'b1;
		status_ch.data <= s;
		@(posedge clk);
		while (!status_ch.ready) @(posedge clk);
	endtask

	// the first edge makes sure the last accepted beat has its expectation queued
	task automatic drain();
		status_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_leds.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input signal_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_directed();
		status_t s;
		s = '1;
		send_status(s);
		for (int i = 0; i < 6; i++) begin
			s = '0;
			if (i < 2)
				s.modem_init = 1'b1;
			else if (i < 4)
				s.ota_active = 1'b1;
			else
				s.link_active = 1'b1;
			send_status(s);
		end
		for (int i = 0; i < 18; i++) begin
			s = '0;
			s.network_level = level_t'(i % 8);
			s.key_test = level_t'(7 - i % 8);
			s.alarm = (i % 3 == 0);
			s.low_battery = (i % 3 == 1);
			s.gps_signal = (i % 3 == 0) ? signal_t'(0) : (i % 3 == 1) ? signal_t'(99)
				: signal_t'(127);
			s.gps_fix = i[0];
			s.no_sim = i[1];
			s.data_connected = i[2];
			send_status(s);
		end
	endtask

	// an ota pair leaves the modem phase at 0 or 1, so the next ten ticks pass phase 8
	task automatic test_threshold_settings();
		signal_t settings[5] = '{7'd0, 7'd99, 7'd127, 7'd42, THRESHOLD_RESET};
		status_t s;
		foreach (settings[n]) begin
			drain();
			write_threshold(settings[n]);
			for (int r = 0; r < 4; r++) begin
				s = '0;
				s.ota_active = 1'b1;
				send_status(s);
				send_status(s);
				for (int k = 0; k < 10; k++) begin
					s = '0;
					s.data_connected = 1'b1;
					s.no_sim = (r == 3) && k[0];
					s.network_level = level_t'($urandom_range(0, 7));
					s.gps_fix = 1'($urandom_range(0, 1));
					case (r)
						0: s.gps_signal = signal_t'(settings[n] - 7'd1);
						1: s.gps_signal = settings[n];
						2: s.gps_signal = signal_t'(settings[n] + 7'd1);
						default: s.gps_signal = signal_t'($urandom_range(0, 127));
					endcase
					send_status(s);
				end
			end
		end
	endtask

	// mostly long quiet stretches so every counter runs its full cycle
	task automatic test_random_traffic();
		status_t s;
		int sent;
		int len;
		int kind;
		logic alarm_hold;
		logic lowbat_hold;
		sent = 0;
		while (sent < 450) begin
			if ($urandom_range(0, 9) == 0) begin
				drain();
				write_threshold(signal_t'($urandom_range(0, 127)));
			end
			kind = $urandom_range(0, 9);
			alarm_hold = ($urandom_range(0, 2) == 0);
			lowbat_hold = ($urandom_range(0, 2) == 0);
			if (kind <= 5)
				len = $urandom_range(20, 150);
			else if (kind == 6)
				len = $urandom_range(3, 30);
			else if (kind == 7)
				len = $urandom_range(1, 6);
			else if (kind == 8)
				len = $urandom_range(5, 50);
			else
				len = $urandom_range(5, 20);
			for (int i = 0; i < len; i++) begin
				s = status_t'($urandom);
				if (kind <= 5) begin
					s.power_off = ($urandom_range(0, 49) == 0);
					s.modem_init = ($urandom_range(0, 59) == 0);
					s.ota_active = ($urandom_range(0, 59) == 0);
					s.link_active = ($urandom_range(0, 59) == 0);
					s.alarm = alarm_hold;
					s.low_battery = lowbat_hold;
					s.key_test = ($urandom_range(0, 3) == 0) ? level_t'($urandom_range(1, 7))
						: KEY_NONE;
					s.no_sim = ($urandom_range(0, 4) == 0);
					s.data_connected = ($urandom_range(0, 3) != 0);
					s.gps_signal = signal_t'($urandom_range(0, 99));
				end else if (kind == 6) begin
					s.power_off = 1'b0;
					s.modem_init = 1'b1;
				end else if (kind == 7) begin
					s.power_off = 1'b0;
					s.modem_init = 1'b0;
					s.ota_active = 1'b1;
				end else if (kind == 8) begin
					s.power_off = 1'b0;
					s.modem_init = 1'b0;
					s.ota_active = 1'b0;
					s.link_active = 1'b1;
				end
				send_status(s);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		status_ch.valid <= 1'b0;
		status_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= THRESHOLD_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_threshold_settings();
		test_random_traffic();

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && expected_leds.size() == 0)
			$display("status_led_pattern_sequencer_tb: clean");
		else
			$display("status_led_pattern_sequencer_tb: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status_led_pattern_sequencer_tb: errors");
		$finish;
	end

endmodule

// ===== status_led_pattern_sequencer.f =====
hw/rtl/slps_pkg.sv
hw/rtl/slps_chan_if.sv
hw/rtl/status_led_pattern_sequencer.sv
verif/status_led_pattern_sequencer_tb.sv
